### design/tmps_pkg.sv
`timescale 1ns / 1ps
// tmps_pkg: shared constants, state type and memory control word for the
// totient / mertens prefix sieve. no dependencies.
package tmps_pkg;

  localparam int TABLE_SIZE = 65536;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int QIDX_W     = 20;
  localparam int TOT_W      = 32;
  localparam int MOB_W      = 11;
  localparam int PRIME_CAP  = 13107;
  localparam int PADDR_W    = $clog2(PRIME_CAP);
  localparam int PC_W       = $clog2(PRIME_CAP + 1);
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = IDX_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);
  localparam logic [MOB_W-1:0] MOB_MAX  = {1'b0, {(MOB_W-1){1'b1}}};
  localparam logic [MOB_W-1:0] MOB_MIN  = {1'b1, {(MOB_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_RD_I,
    ST_CHK,
    ST_RD_P,
    ST_MUL_I,
    ST_MUL_PHI,
    ST_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_QRD,
    ST_QOUT
  } state_t;

  typedef struct packed {
    logic               we_spf;
    logic               we_tbl;
    logic [IDX_W-1:0]   addr_w;
    logic [IDX_W-1:0]   addr_r;
    logic [IDX_W-1:0]   spf_wdata;
    logic [TOT_W-1:0]   tot_wdata;
    logic [MOB_W-1:0]   mob_wdata;
    logic               we_pl;
    logic [PADDR_W-1:0] pl_waddr;
    logic [PADDR_W-1:0] pl_raddr;
    logic [IDX_W-1:0]   pl_wdata;
  } mem_ctl_t;

endpackage

### design/tmps_ram.sv
`timescale 1ns / 1ps
// tmps_ram: generic simple dual-port ram, one write port, one registered
// read port. no dependencies.
module tmps_ram #(
  parameter int W = 16,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/tmps_mul.sv
`timescale 1ns / 1ps
// tmps_mul: shared registered multiplier, low word of a 32 x 16 product.
// depends on tmps_pkg.
module tmps_mul (
  input  logic                           clk,
  input  logic [tmps_pkg::MUL_A_W-1:0]   a,
  input  logic [tmps_pkg::MUL_B_W-1:0]   b,
  output logic [tmps_pkg::MUL_A_W-1:0]   q
);
  import tmps_pkg::*;

  logic [MUL_A_W+MUL_B_W-1:0] full;

  assign full = (MUL_A_W+MUL_B_W)'(a) * (MUL_A_W+MUL_B_W)'(b);

  always_ff @(posedge clk) begin
    q <= full[MUL_A_W-1:0];
  end

endmodule

### design/tmps_ctrl.sv
`timescale 1ns / 1ps
// tmps_ctrl: sequencer for the clear pass, linear sieve, prefix pass and
// query reads; drives the memories and the shared multiplier. uses tmps_pkg.
module tmps_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tmps_pkg::QIDX_W-1:0]         in_query_index,
  output logic                                busy,
  output tmps_pkg::mem_ctl_t                  mem,
  input  logic [tmps_pkg::IDX_W-1:0]          spf_rdata,
  input  logic [tmps_pkg::TOT_W-1:0]          tot_rdata,
  input  logic [tmps_pkg::MOB_W-1:0]          mob_rdata,
  input  logic [tmps_pkg::IDX_W-1:0]          pl_rdata,
  output logic [tmps_pkg::MUL_A_W-1:0]        mul_a,
  output logic [tmps_pkg::MUL_B_W-1:0]        mul_b,
  input  logic [tmps_pkg::MUL_A_W-1:0]        mul_q,
  output logic                                out_valid,
  output logic [tmps_pkg::TOT_W-1:0]          out_totient_sum,
  output logic signed [tmps_pkg::MOB_W-1:0]   out_mertens_sum,
  output logic                                out_out_of_range
);
  import tmps_pkg::*;

  state_t             state_r, state_nxt;
  logic               built_r, built_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [PC_W-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0]   p_r, p_nxt;
  logic [IDX_W-1:0]   m_r, m_nxt;
  logic [IDX_W-1:0]   cur_spf_r, cur_spf_nxt;
  logic [TOT_W-1:0]   cur_phi_r, cur_phi_nxt;
  logic [MOB_W-1:0]   cur_mu_r, cur_mu_nxt;
  logic [TOT_W-1:0]   acc_t_r, acc_t_nxt;
  logic [MOB_W-1:0]   acc_m_r, acc_m_nxt;
  logic [IDX_W-1:0]   q_idx_r, q_idx_nxt;
  logic               q_oor_r, q_oor_nxt;
  logic [TOT_W-1:0]   o_tot_r, o_tot_nxt;
  logic [MOB_W-1:0]   o_mob_r, o_mob_nxt;
  logic               o_oor_r, o_oor_nxt;
  logic               match;
  logic [TOT_W:0]     sum_t;
  logic [MOB_W:0]     sum_m;
  logic [TOT_W-1:0]   sat_t;
  logic [MOB_W-1:0]   sat_m;

  assign match = (cur_spf_r == p_r);
  assign sum_t = {1'b0, acc_t_r} + {1'b0, tot_rdata};
  assign sum_m = {acc_m_r[MOB_W-1], acc_m_r} + {mob_rdata[MOB_W-1], mob_rdata};
  assign sat_t = sum_t[TOT_W] ? '1 : sum_t[TOT_W-1:0];
  assign sat_m = (sum_m[MOB_W] == sum_m[MOB_W-1]) ? sum_m[MOB_W-1:0] :
                 (sum_m[MOB_W] ? MOB_MIN : MOB_MAX);

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_totient_sum  = o_tot_r;
  assign out_mertens_sum  = o_mob_r;
  assign out_out_of_range = o_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      built_r     <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    p_r       <= p_nxt;
    m_r       <= m_nxt;
    cur_spf_r <= cur_spf_nxt;
    cur_phi_r <= cur_phi_nxt;
    cur_mu_r  <= cur_mu_nxt;
    acc_t_r   <= acc_t_nxt;
    acc_m_r   <= acc_m_nxt;
    q_idx_r   <= q_idx_nxt;
    q_oor_r   <= q_oor_nxt;
    o_tot_r   <= o_tot_nxt;
    o_mob_r   <= o_mob_nxt;
    o_oor_r   <= o_oor_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    built_nxt     = built_r;
    pc_nxt        = pc_r;
    out_valid_nxt = 1'b0;
    i_nxt         = i_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    cur_spf_nxt   = cur_spf_r;
    cur_phi_nxt   = cur_phi_r;
    cur_mu_nxt    = cur_mu_r;
    acc_t_nxt     = acc_t_r;
    acc_m_nxt     = acc_m_r;
    q_idx_nxt     = q_idx_r;
    q_oor_nxt     = q_oor_r;
    o_tot_nxt     = o_tot_r;
    o_mob_nxt     = o_mob_r;
    o_oor_nxt     = o_oor_r;
    mem           = '0;
    mem.addr_r    = i_r;
    mul_a         = cur_phi_r;
    mul_b         = match ? p_r : p_r - IDX_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        mem.addr_r = in_query_index[IDX_W-1:0];
        if (start) begin
          q_idx_nxt = in_query_index[IDX_W-1:0];
          q_oor_nxt = (in_query_index >= QIDX_W'(TABLE_SIZE));
          if (built_r) begin
            state_nxt = ST_QOUT;
          end else begin
            i_nxt     = '0;
            pc_nxt    = '0;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        mem.we_spf = 1'b1;
        mem.we_tbl = 1'b1;
        mem.addr_w = i_r;
        if (i_r == IDX_LAST) begin
          state_nxt = ST_INIT;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      ST_INIT: begin
        mem.we_spf    = 1'b1;
        mem.we_tbl    = 1'b1;
        mem.addr_w    = IDX_W'(1);
        mem.spf_wdata = IDX_W'(1);
        mem.tot_wdata = TOT_W'(1);
        mem.mob_wdata = MOB_W'(1);
        i_nxt         = IDX_W'(2);
        state_nxt     = ST_RD_I;
      end
      ST_RD_I: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        j_nxt     = '0;
        state_nxt = ST_RD_P;
        if (spf_rdata == '0) begin
          // new prime
          mem.we_spf    = 1'b1;
          mem.we_tbl    = 1'b1;
          mem.addr_w    = i_r;
          mem.spf_wdata = i_r;
          mem.tot_wdata = TOT_W'(i_r) - TOT_W'(1);
          mem.mob_wdata = '1;
          cur_spf_nxt   = i_r;
          cur_phi_nxt   = TOT_W'(i_r) - TOT_W'(1);
          cur_mu_nxt    = '1;
          if (pc_r < PC_W'(PRIME_CAP)) begin
            mem.we_pl    = 1'b1;
            mem.pl_waddr = pc_r[PADDR_W-1:0];
            mem.pl_wdata = i_r;
            pc_nxt       = pc_r + PC_W'(1);
          end
        end else begin
          cur_spf_nxt = spf_rdata;
          cur_phi_nxt = tot_rdata;
          cur_mu_nxt  = mob_rdata;
        end
      end
      ST_RD_P: begin
        if (j_r < pc_r) begin
          mem.pl_raddr = j_r[PADDR_W-1:0];
          state_nxt    = ST_MUL_I;
        end else if (i_r == IDX_LAST) begin
          i_nxt     = IDX_W'(1);
          acc_t_nxt = '0;
          acc_m_nxt = '0;
          state_nxt = ST_PFX_RD;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_RD_I;
        end
      end
      ST_MUL_I: begin
        mul_a     = MUL_A_W'(i_r);
        mul_b     = pl_rdata;
        p_nxt     = pl_rdata;
        state_nxt = ST_MUL_PHI;
      end
      ST_MUL_PHI: begin
        if (mul_q >= MUL_A_W'(TABLE_SIZE)) begin
          if (i_r == IDX_LAST) begin
            i_nxt     = IDX_W'(1);
            acc_t_nxt = '0;
            acc_m_nxt = '0;
            state_nxt = ST_PFX_RD;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = ST_RD_I;
          end
        end else begin
          m_nxt     = mul_q[IDX_W-1:0];
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        mem.we_spf    = 1'b1;
        mem.we_tbl    = 1'b1;
        mem.addr_w    = m_r;
        mem.spf_wdata = p_r;
        mem.tot_wdata = mul_q;
        mem.mob_wdata = match ? '0 : MOB_W'(0) - cur_mu_r;
        if (match) begin
          if (i_r == IDX_LAST) begin
            i_nxt     = IDX_W'(1);
            acc_t_nxt = '0;
            acc_m_nxt = '0;
            state_nxt = ST_PFX_RD;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = ST_RD_I;
          end
        end else begin
          j_nxt     = j_r + PC_W'(1);
          state_nxt = ST_RD_P;
        end
      end
      ST_PFX_RD: begin
        state_nxt = ST_PFX_WR;
      end
      ST_PFX_WR: begin
        mem.we_tbl    = 1'b1;
        mem.addr_w    = i_r;
        mem.tot_wdata = sat_t;
        mem.mob_wdata = sat_m;
        acc_t_nxt     = sat_t;
        acc_m_nxt     = sat_m;
        if (i_r == IDX_LAST) begin
          built_nxt = 1'b1;
          state_nxt = ST_QRD;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_PFX_RD;
        end
      end
      ST_QRD: begin
        mem.addr_r = q_idx_r;
        state_nxt  = ST_QOUT;
      end
      ST_QOUT: begin
        out_valid_nxt = 1'b1;
        o_oor_nxt     = q_oor_r;
        o_tot_nxt     = q_oor_r ? '0 : tot_rdata;
        o_mob_nxt     = q_oor_r ? '0 : mob_rdata;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/totient_mobius_prefix_sieve_top.sv
`timescale 1ns / 1ps
// totient_mobius_prefix_sieve_top: phi and mu prefix sums over a sieved table.
// depends on tmps_pkg, tmps_ram, tmps_mul and tmps_ctrl.
//
//   channel   ports                                             flow
//   query     start, busy, in_query_index                       start while !busy
//   result    out_valid, out_totient_sum, out_mertens_sum,     one-cycle strobe
//             out_out_of_range
//
// the first query after reset builds the tables: a clear sweep, the linear
// sieve (bound by the single read port of each table and the shared
// multiplier), then a prefix pass. later queries read the tables while idle,
// then pass through ST_QOUT to the registered result strobe.
// rst_n is synchronous and forces a rebuild on the next query.
// the receiver cannot stall; busy holds off new queries.
module totient_mobius_prefix_sieve_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tmps_pkg::QIDX_W-1:0]        in_query_index,
  output logic                               out_valid,
  output logic [tmps_pkg::TOT_W-1:0]         out_totient_sum,
  output logic signed [tmps_pkg::MOB_W-1:0]  out_mertens_sum,
  output logic                               out_out_of_range
);
  import tmps_pkg::*;

  mem_ctl_t             mem;
  logic [IDX_W-1:0]     spf_rdata;
  logic [TOT_W-1:0]     tot_rdata;
  logic [MOB_W-1:0]     mob_rdata;
  logic [IDX_W-1:0]     pl_rdata;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_A_W-1:0]   mul_q;

  tmps_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_query_index   (in_query_index),
    .busy             (busy),
    .mem              (mem),
    .spf_rdata        (spf_rdata),
    .tot_rdata        (tot_rdata),
    .mob_rdata        (mob_rdata),
    .pl_rdata         (pl_rdata),
    .mul_a            (mul_a),
    .mul_b            (mul_b),
    .mul_q            (mul_q),
    .out_valid        (out_valid),
    .out_totient_sum  (out_totient_sum),
    .out_mertens_sum  (out_mertens_sum),
    .out_out_of_range (out_out_of_range)
  );

  tmps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  tmps_ram #(.W(IDX_W), .D(TABLE_SIZE)) u_spf_ram (
    .clk   (clk),
    .we    (mem.we_spf),
    .waddr (mem.addr_w),
    .wdata (mem.spf_wdata),
    .raddr (mem.addr_r),
    .rdata (spf_rdata)
  );

  tmps_ram #(.W(TOT_W), .D(TABLE_SIZE)) u_tot_ram (
    .clk   (clk),
    .we    (mem.we_tbl),
    .waddr (mem.addr_w),
    .wdata (mem.tot_wdata),
    .raddr (mem.addr_r),
    .rdata (tot_rdata)
  );

  tmps_ram #(.W(MOB_W), .D(TABLE_SIZE)) u_mob_ram (
    .clk   (clk),
    .we    (mem.we_tbl),
    .waddr (mem.addr_w),
    .wdata (mem.mob_wdata),
    .raddr (mem.addr_r),
    .rdata (mob_rdata)
  );

  tmps_ram #(.W(IDX_W), .D(PRIME_CAP)) u_prime_ram (
    .clk   (clk),
    .we    (mem.we_pl),
    .waddr (mem.pl_waddr),
    .wdata (mem.pl_wdata),
    .raddr (mem.pl_raddr),
    .rdata (pl_rdata)
  );

  a_word_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a query in flight");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("query accepted but block not busy");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_totient_sum == '0 && out_mertens_sum == '0))
    else $error("out-of-range word carries nonzero sums");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (!mem.we_spf && !mem.we_tbl && !mem.we_pl))
    else $error("table write while idle");

endmodule
